// ----- rtl/core/peak_load_tracker_core_assert.svh -----
// assertion macros for the peak load tracker checker
`ifndef PEAK_LOAD_TRACKER_CORE_ASSERT_SVH
`define PEAK_LOAD_TRACKER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PLT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("peak load tracker check failed");

// next-cycle implication, sampled on clk, off during reset
`define PLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("peak load tracker check failed");

`endif

// ----- rtl/core/plt_pkg.sv -----
// types and constants of the peak load tracker
package plt_pkg;

    localparam int unsigned OUT_W = 32;
    localparam int unsigned PCT_SQUARE = 10000;
    localparam logic [7:0] PERIOD_RESET = 8'd11;

    typedef struct packed {
        logic [31:0] sample_load;
        logic        reset_request;
    } in_item_t;

    typedef struct packed {
        logic        updated;
        logic [31:0] load_out;
        logic [31:0] total_out;
    } out_item_t;

endpackage

// ----- rtl/core/plt_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module plt_div #(
    parameter int unsigned DDW = 46,
    parameter int unsigned DVW = 39
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DDW-1:0] dividend,
    input  logic [DVW-1:0] divisor,
    output logic           done,
    output logic [DDW-1:0] quotient
);

    localparam int unsigned CW = (DDW > 1) ? $clog2(DDW) : 1;

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [DVW-1:0] dvs_reg, dvs_next;
    logic [DDW-1:0] quo_reg, quo_next;
    logic [DVW:0]   shifted;
    logic [DVW:0]   diff;
    logic           ge;

    assign shifted = {rem_reg, quo_reg[DDW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DVW-1:0] : shifted[DVW-1:0];
            quo_next = {quo_reg[DDW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DDW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/peak_load_tracker_core.sv -----
// peak load tracker top level: period counter, peak and reference, correction sequencer
// reset request and latch step: from the transfer straight to ST_OUT; plain step through ST_MAX, then ST_OUT
// period step: up to five divisions on the shared bit-serial divider, each started in ST_LOAD and awaited in ST_WAIT,
// then ST_MAX and ST_OUT (three divisions when the rise test fails, none when the sample or the peak is zero)
// one sample in work at a time; the next transfer can come the cycle after the result registers
// reset clears peak, reference and counter and sets the correction period to 11
module peak_load_tracker_core #(
    parameter int unsigned LOAD_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  plt_pkg::in_item_t  sample,
    output logic               result_valid,
    input  logic               result_ready,
    output plt_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);

    import plt_pkg::*;

    localparam int unsigned PW = LOAD_WIDTH + 7;
    localparam int unsigned DW = LOAD_WIDTH + 14;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_MAX  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [2:0] STEP_P0 = 3'd0;
    localparam logic [2:0] STEP_P1 = 3'd1;
    localparam logic [2:0] STEP_P2 = 3'd2;
    localparam logic [2:0] STEP_Q3 = 3'd3;
    localparam logic [2:0] STEP_Q4 = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [2:0]            step_reg, step_next;
    logic [7:0]            period_reg, period_next;
    logic [7:0]            count_reg, count_next;
    logic [LOAD_WIDTH-1:0] peak_reg, peak_next;
    logic [LOAD_WIDTH-1:0] ref_reg, ref_next;
    logic [LOAD_WIDTH-1:0] sample_reg, sample_next;
    logic                  repl_reg, repl_next;
    logic                  res_valid_reg, res_valid_next;
    logic [PW-1:0]         p0_reg, p0_next;
    logic [PW-1:0]         p1_reg, p1_next;
    logic [PW-1:0]         p2_reg, p2_next;
    logic [DW-1:0]         q3_reg, q3_next;
    out_item_t             pend_reg, pend_next;
    out_item_t             res_reg, res_next;

    logic [LOAD_WIDTH-1:0] smp;
    logic [7:0]            cnt_inc;
    logic [7:0]            latch_at;
    logic [LOAD_WIDTH-1:0] peak_new;
    logic                  div_start;
    logic                  div_done;
    logic [DW-1:0]         div_quo;
    logic [DW-1:0]         div_dividend;
    logic [PW-1:0]         div_divisor;
    logic [DW-1:0]         ref_w;
    logic [DW-1:0]         smp_w;
    logic [DW-1:0]         p2_w;
    logic [DW-1:0]         ref_x100;
    logic [DW-1:0]         smp_x100;
    logic [DW-1:0]         p2_x105;

    assign smp      = LOAD_WIDTH'(sample.sample_load);
    assign cnt_inc  = count_reg + 8'd1;
    assign latch_at = period_reg - 8'd1;
    assign peak_new = (repl_reg || (sample_reg > peak_reg)) ? sample_reg : peak_reg;

    // constant multiplies as shift-add: 100 = 64+32+4, 105 = 64+32+8+1
    assign ref_w    = DW'(ref_reg);
    assign smp_w    = DW'(sample_reg);
    assign p2_w     = DW'(p2_reg);
    assign ref_x100 = (ref_w << 6) + (ref_w << 5) + (ref_w << 2);
    assign smp_x100 = (smp_w << 6) + (smp_w << 5) + (smp_w << 2);
    assign p2_x105  = (p2_w << 6) + (p2_w << 5) + (p2_w << 3) + p2_w;

    always_comb
    begin
        case (step_reg)
            STEP_P0:
            begin
                div_dividend = ref_x100;
                div_divisor  = PW'(sample_reg);
            end
            STEP_P1:
            begin
                div_dividend = ref_x100;
                div_divisor  = PW'(peak_reg);
            end
            STEP_P2:
            begin
                div_dividend = smp_x100;
                div_divisor  = PW'(peak_reg);
            end
            STEP_Q3:
            begin
                div_dividend = p2_x105;
                div_divisor  = p1_reg;
            end
            default:
            begin
                div_dividend = DW'(PCT_SQUARE);
                div_divisor  = p0_reg;
            end
        endcase
    end

    plt_div #(
        .DDW (DW),
        .DVW (PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        period_next    = period_reg;
        count_next     = count_reg;
        peak_next      = peak_reg;
        ref_next       = ref_reg;
        sample_next    = sample_reg;
        repl_next      = repl_reg;
        res_valid_next = res_valid_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        q3_next        = q3_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        div_start      = 1'b0;

        if (cfg_valid)
        begin
            period_next = cfg_data;
        end

        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    sample_next = smp;
                    repl_next   = 1'b0;
                    if (sample.reset_request)
                    begin
                        peak_next  = '0;
                        count_next = '0;
                        pend_next  = '{updated: 1'b0, load_out: '0, total_out: '0};
                        state_next = ST_OUT;
                    end
                    else if (cnt_inc == latch_at)
                    begin
                        ref_next   = smp;
                        count_next = cnt_inc;
                        pend_next  = '{updated: 1'b1, load_out: OUT_W'(peak_reg),
                                       total_out: OUT_W'(peak_reg)};
                        state_next = ST_OUT;
                    end
                    else if (cnt_inc == period_reg)
                    begin
                        count_next = '0;
                        if ((smp == '0) || (peak_reg == '0))
                        begin
                            state_next = ST_MAX;
                        end
                        else
                        begin
                            step_next  = STEP_P0;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        count_next = cnt_inc;
                        state_next = ST_MAX;
                    end
                end
            end
            ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    case (step_reg)
                        STEP_P0:
                        begin
                            p0_next    = PW'(div_quo);
                            step_next  = STEP_P1;
                            state_next = ST_LOAD;
                        end
                        STEP_P1:
                        begin
                            p1_next    = PW'(div_quo);
                            step_next  = STEP_P2;
                            state_next = ST_LOAD;
                        end
                        STEP_P2:
                        begin
                            p2_next = PW'(div_quo);
                            if ((p0_reg == '0) || (p1_reg == '0) || (PW'(div_quo) <= p1_reg))
                            begin
                                state_next = ST_MAX;
                            end
                            else
                            begin
                                step_next  = STEP_Q3;
                                state_next = ST_LOAD;
                            end
                        end
                        STEP_Q3:
                        begin
                            q3_next    = div_quo;
                            step_next  = STEP_Q4;
                            state_next = ST_LOAD;
                        end
                        default:
                        begin
                            repl_next  = q3_reg < div_quo;
                            state_next = ST_MAX;
                        end
                    endcase
                end
            end
            ST_MAX:
            begin
                peak_next  = peak_new;
                pend_next  = '{updated: 1'b1, load_out: OUT_W'(sample_reg),
                               total_out: OUT_W'(peak_new)};
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_P0;
            period_reg    <= PERIOD_RESET;
            count_reg     <= '0;
            peak_reg      <= '0;
            ref_reg       <= '0;
            repl_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            period_reg    <= period_next;
            count_reg     <= count_next;
            peak_reg      <= peak_next;
            ref_reg       <= ref_next;
            repl_reg      <= repl_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        q3_reg     <= q3_next;
        pend_reg   <= pend_next;
        res_reg    <= res_next;
    end

    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign cfg_ready    = 1'b1;

endmodule

// ----- rtl/core/plt_checker.sv -----
// port-level checks of the peak load tracker, bound to the top level
`include "peak_load_tracker_core_assert.svh"

module plt_checker #(
    parameter int unsigned LOAD_WIDTH = 32
) (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_ready,
    input plt_pkg::out_item_t result,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    import plt_pkg::*;

    localparam logic NARROW = (LOAD_WIDTH <= OUT_W);

    logic zero_out;
    logic load_le_total;

    assign zero_out      = (result.load_out == 32'd0) && (result.total_out == 32'd0);
    assign load_le_total = (result.load_out <= result.total_out);

    // stalled result stays put
    `PLT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

    // a cleared step reports zeros
    `PLT_ASSERT_NOW(a_clear_zero, result_valid && !result.updated, zero_out)

    // reported load never exceeds the running peak
    `PLT_ASSERT_NOW(a_load_le_total, NARROW && result_valid && result.updated, load_le_total)

    // register writes are never held off
    `PLT_ASSERT_NOW(a_cfg_taken, cfg_valid, cfg_ready)

endmodule

bind peak_load_tracker_core plt_checker #(.LOAD_WIDTH(LOAD_WIDTH)) u_plt_checker (.*);
